[rtl/rdmc_pkg.sv]
// Shared types, direction codes and shuffle helpers for the maze carver.
`timescale 1ns / 1ps
package rdmc_pkg;

   localparam int DEF_GRID_COLS = 16;
   localparam int DEF_GRID_ROWS = 16;

   typedef logic [1:0] dir_type;
   typedef logic [7:0] order_type;
   typedef logic [2:0] slot_type;

   localparam int ORDER_W = 8;
   localparam int NEXT_W  = 3;

   localparam dir_type DIR_UP    = 2'd0;
   localparam dir_type DIR_RIGHT = 2'd1;
   localparam dir_type DIR_DOWN  = 2'd2;
   localparam dir_type DIR_LEFT  = 2'd3;

   // slot i of an order sits at bits [2i+1:2i]
   localparam order_type ORDER_INIT = {DIR_LEFT, DIR_DOWN, DIR_RIGHT, DIR_UP};
   localparam slot_type  SLOT_FIRST = 3'd0;
   localparam slot_type  SLOT_END   = 3'd4;

   function automatic dir_type order_slot(order_type ord, logic [1:0] slot);
      return ord[2*slot +: 2];
   endfunction

   function automatic order_type swap_slot(order_type ord, logic [1:0] a, logic [1:0] b);
      order_type r;
      dir_type   t;
      r = ord;
      t = r[2*a +: 2];
      r[2*a +: 2] = r[2*b +: 2];
      r[2*b +: 2] = t;
      return r;
   endfunction

   function automatic order_type shuffle_order(logic [1:0] p0, logic [1:0] p1,
                                               logic [1:0] p2);
      return swap_slot(swap_slot(swap_slot(ORDER_INIT, 2'd0, p0), 2'd1, p1), 2'd2, p2);
   endfunction

endpackage

[rtl/rdmc_ram.sv]
// Single-port-write, registered-read memory used for the visited map and the frame stack.
`timescale 1ns / 1ps
module rdmc_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rdmc_nbr_unit.sv]
// Neighbour step unit: moves one cell in a direction, checks the grid edge, forms the address.
`timescale 1ns / 1ps
module rdmc_nbr_unit #(
   parameter int GRID_COLS = rdmc_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS = rdmc_pkg::DEF_GRID_ROWS,
   parameter int X_W       = $clog2(GRID_COLS),
   parameter int Y_W       = $clog2(GRID_ROWS),
   parameter int ADDR_W    = $clog2(GRID_COLS * GRID_ROWS)
) (
   input  logic [X_W-1:0]    cur_x,
   input  logic [Y_W-1:0]    cur_y,
   input  rdmc_pkg::dir_type dir,
   output logic [X_W-1:0]    nbr_x,
   output logic [Y_W-1:0]    nbr_y,
   output logic [ADDR_W-1:0] nbr_addr,
   output logic              nbr_ok
);
   import rdmc_pkg::*;

   always_comb begin
      nbr_x  = cur_x;
      nbr_y  = cur_y;
      nbr_ok = 1'b0;
      unique case (dir)
         DIR_UP: begin
            nbr_ok = (cur_y != '0);
            nbr_y  = cur_y - Y_W'(1);
         end
         DIR_RIGHT: begin
            nbr_ok = (cur_x != X_W'(GRID_COLS - 1));
            nbr_x  = cur_x + X_W'(1);
         end
         DIR_DOWN: begin
            nbr_ok = (cur_y != Y_W'(GRID_ROWS - 1));
            nbr_y  = cur_y + Y_W'(1);
         end
         DIR_LEFT: begin
            nbr_ok = (cur_x != '0);
            nbr_x  = cur_x - X_W'(1);
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end

   assign nbr_addr = ADDR_W'(nbr_y) * ADDR_W'(GRID_COLS) + ADDR_W'(nbr_x);

endmodule

[rtl/random_dfs_maze_carver_core.sv]
// Top level of the randomised depth-first maze carver: sequencer, top-frame cache, memories.
`timescale 1ns / 1ps
// Each request, unless the maze is already finished, enters one cell: it is marked visited
// and pushed with a direction order shuffled by the three picks, then the block tries
// directions of the top frame and pops exhausted frames until it finds an unvisited in-grid
// neighbour, answering with one carve transfer (cell and direction) or, once the stack
// empties, a finished transfer; a later request without restart gets a finished transfer.
// An item is accepted, enters its cell, tries directions one at a time (an in-grid direction
// waits for a visited-map read), pops exhausted frames (reloading the frame below from the
// stack) and hands the result over, bounded by the single neighbour unit and the one read
// port of each memory. After reset and after every restart request the visited map is
// swept clear, one cell per cycle; no request is taken during the sweep. A new request is
// taken while a result waits.
module random_dfs_maze_carver_core #(
   parameter int GRID_COLS = rdmc_pkg::DEF_GRID_COLS,
   parameter int GRID_ROWS = rdmc_pkg::DEF_GRID_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_restart,
   input  logic [1:0]        req_pick_first,
   input  logic [1:0]        req_pick_second,
   input  logic [1:0]        req_pick_third,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_cell_x,
   output logic [3:0]        rsp_cell_y,
   output rdmc_pkg::dir_type rsp_direction,
   output logic              rsp_finished
);
   import rdmc_pkg::*;

   localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
   localparam int X_W        = $clog2(GRID_COLS);
   localparam int Y_W        = $clog2(GRID_ROWS);
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
   localparam int FRAME_W    = X_W + Y_W + ORDER_W + NEXT_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ENTER,
      S_TRY,
      S_LOAD,
      S_CHECK,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [X_W-1:0]     top_x_ff, top_x_in;
   logic [Y_W-1:0]     top_y_ff, top_y_in;
   order_type          top_order_ff, top_order_in;
   slot_type           top_next_ff, top_next_in;
   logic [X_W-1:0]     enter_x_ff, enter_x_in;
   logic [Y_W-1:0]     enter_y_ff, enter_y_in;
   logic [ADDR_W-1:0]  enter_addr_ff, enter_addr_in;
   logic               done_ff, done_in;
   logic [1:0]         pick0_ff, pick0_in, pick1_ff, pick1_in, pick2_ff, pick2_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               clr_enter_ff, clr_enter_in;
   logic [X_W-1:0]     nb_x_ff, nb_x_in;
   logic [Y_W-1:0]     nb_y_ff, nb_y_in;
   dir_type            nb_dir_ff, nb_dir_in;
   logic [3:0]         res_x_ff, res_x_in, res_y_ff, res_y_in;
   dir_type            res_dir_ff, res_dir_in;
   logic               res_fin_ff, res_fin_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   dir_type            rsp_dir_ff, rsp_dir_in;
   logic               rsp_fin_ff, rsp_fin_in;

   dir_type            try_dir;
   logic [X_W-1:0]     nu_x;
   logic [Y_W-1:0]     nu_y;
   logic [ADDR_W-1:0]  nu_addr;
   logic               nu_ok;
   logic [X_W+3:0]     top_x_wide;
   logic [Y_W+3:0]     top_y_wide;
   logic [DEPTH_W-1:0] depth_m1, depth_m2;
   logic               stack_full;

   logic               vm_we, vm_wdata, vm_re, vm_rdata;
   logic [ADDR_W-1:0]  vm_waddr, vm_raddr;
   logic               st_we, st_re;
   logic [ADDR_W-1:0]  st_waddr, st_raddr;
   logic [FRAME_W-1:0] st_wdata, st_rdata;

   assign try_dir    = order_slot(top_order_ff, top_next_ff[1:0]);
   assign top_x_wide = {4'b0000, top_x_ff};
   assign top_y_wide = {4'b0000, top_y_ff};
   assign depth_m1   = depth_ff - DEPTH_W'(1);
   assign depth_m2   = depth_ff - DEPTH_W'(2);
   assign stack_full = (depth_ff == DEPTH_W'(CELL_COUNT));

   rdmc_nbr_unit #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_nbr (
      .cur_x    (top_x_ff),
      .cur_y    (top_y_ff),
      .dir      (try_dir),
      .nbr_x    (nu_x),
      .nbr_y    (nu_y),
      .nbr_addr (nu_addr),
      .nbr_ok   (nu_ok)
   );

   rdmc_ram #(
      .WIDTH (1),
      .DEPTH (CELL_COUNT)
   ) u_visited (
      .clock   (clock),
      .wr_en   (vm_we),
      .wr_addr (vm_waddr),
      .wr_data (vm_wdata),
      .rd_en   (vm_re),
      .rd_addr (vm_raddr),
      .rd_data (vm_rdata)
   );

   rdmc_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (CELL_COUNT)
   ) u_stack (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      depth_in      = depth_ff;
      top_x_in      = top_x_ff;
      top_y_in      = top_y_ff;
      top_order_in  = top_order_ff;
      top_next_in   = top_next_ff;
      enter_x_in    = enter_x_ff;
      enter_y_in    = enter_y_ff;
      enter_addr_in = enter_addr_ff;
      done_in       = done_ff;
      pick0_in      = pick0_ff;
      pick1_in      = pick1_ff;
      pick2_in      = pick2_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_enter_in  = clr_enter_ff;
      nb_x_in       = nb_x_ff;
      nb_y_in       = nb_y_ff;
      nb_dir_in     = nb_dir_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_dir_in    = res_dir_ff;
      res_fin_in    = res_fin_ff;

      vm_we    = 1'b0;
      vm_waddr = enter_addr_ff;
      vm_wdata = 1'b1;
      vm_re    = 1'b0;
      vm_raddr = nu_addr;
      st_we    = 1'b0;
      st_waddr = depth_m1[ADDR_W-1:0];
      st_wdata = {top_x_ff, top_y_ff, top_order_ff, top_next_ff};
      st_re    = 1'b0;
      st_raddr = depth_m2[ADDR_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            vm_we    = 1'b1;
            vm_waddr = clr_cnt_ff;
            vm_wdata = 1'b0;
            if (clr_cnt_ff == ADDR_W'(CELL_COUNT - 1)) begin
               clr_cnt_in   = '0;
               clr_enter_in = 1'b0;
               state_in     = clr_enter_ff ? S_ENTER : S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               pick0_in = req_pick_first;
               pick1_in = req_pick_second;
               pick2_in = req_pick_third;
               priority if (req_restart) begin
                  depth_in      = '0;
                  done_in       = 1'b0;
                  enter_x_in    = '0;
                  enter_y_in    = '0;
                  enter_addr_in = '0;
                  clr_cnt_in    = '0;
                  clr_enter_in  = 1'b1;
                  state_in      = S_CLEAR;
               end else if (done_ff) begin
                  res_x_in   = '0;
                  res_y_in   = '0;
                  res_dir_in = DIR_UP;
                  res_fin_in = 1'b1;
                  state_in   = S_EMIT;
               end else begin
                  state_in = S_ENTER;
               end
            end
         end
         S_ENTER: begin
            vm_we = 1'b1;
            if (!stack_full) begin
               // spill the cached top frame before the new one takes its place
               st_we        = (depth_ff != '0);
               top_x_in     = enter_x_ff;
               top_y_in     = enter_y_ff;
               top_order_in = shuffle_order(pick0_ff, pick1_ff, pick2_ff);
               top_next_in  = SLOT_FIRST;
               depth_in     = depth_ff + DEPTH_W'(1);
            end
            state_in = S_TRY;
         end
         S_TRY: begin
            priority if (depth_ff == '0) begin
               done_in    = 1'b1;
               res_x_in   = '0;
               res_y_in   = '0;
               res_dir_in = DIR_UP;
               res_fin_in = 1'b1;
               state_in   = S_EMIT;
            end else if (top_next_ff == SLOT_END) begin
               depth_in = depth_m1;
               if (depth_ff > DEPTH_W'(1)) begin
                  st_re    = 1'b1;
                  state_in = S_LOAD;
               end
            end else begin
               top_next_in = top_next_ff + NEXT_W'(1);
               nb_x_in     = nu_x;
               nb_y_in     = nu_y;
               nb_dir_in   = try_dir;
               if (nu_ok) begin
                  vm_re         = 1'b1;
                  enter_addr_in = nu_addr;
                  state_in      = S_CHECK;
               end
            end
         end
         S_LOAD: begin
            {top_x_in, top_y_in, top_order_in, top_next_in} = st_rdata;
            state_in = S_TRY;
         end
         S_CHECK: begin
            if (vm_rdata) begin
               state_in = S_TRY;
            end else begin
               enter_x_in = nb_x_ff;
               enter_y_in = nb_y_ff;
               res_x_in   = top_x_wide[3:0];
               res_y_in   = top_y_wide[3:0];
               res_dir_in = nb_dir_ff;
               res_fin_in = 1'b0;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: load a new result when empty or being drained
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_fin_in   = rsp_fin_ff;
      if (state_ff == S_EMIT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = res_x_ff;
         rsp_y_in     = res_y_ff;
         rsp_dir_in   = res_dir_ff;
         rsp_fin_in   = res_fin_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         depth_ff      <= '0;
         done_ff       <= 1'b0;
         enter_x_ff    <= '0;
         enter_y_ff    <= '0;
         enter_addr_ff <= '0;
         clr_cnt_ff    <= '0;
         clr_enter_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         depth_ff      <= depth_in;
         done_ff       <= done_in;
         enter_x_ff    <= enter_x_in;
         enter_y_ff    <= enter_y_in;
         enter_addr_ff <= enter_addr_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_enter_ff  <= clr_enter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      top_x_ff     <= top_x_in;
      top_y_ff     <= top_y_in;
      top_order_ff <= top_order_in;
      top_next_ff  <= top_next_in;
      pick0_ff     <= pick0_in;
      pick1_ff     <= pick1_in;
      pick2_ff     <= pick2_in;
      nb_x_ff      <= nb_x_in;
      nb_y_ff      <= nb_y_in;
      nb_dir_ff    <= nb_dir_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      res_dir_ff   <= res_dir_in;
      res_fin_ff   <= res_fin_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_x    = rsp_x_ff;
   assign rsp_cell_y    = rsp_y_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_finished  = rsp_fin_ff;

endmodule

[tb/sv/random_dfs_maze_carver_core_tb.sv]
// Self-checking testbench for the maze carver: directed rows, random mazes, scoreboard.
`timescale 1ns / 1ps
module random_dfs_maze_carver_core_tb;
   import rdmc_pkg::*;

   localparam int COLS       = DEF_GRID_COLS;
   localparam int ROWS       = DEF_GRID_ROWS;
   localparam int CELLS      = COLS * ROWS;
   localparam int PHASE_LEN  = 500;
   localparam int CYCLE_CAP  = 400000;
   localparam int TAIL_WAIT  = 50;

   typedef struct packed {
      logic [3:0] cell_x;
      logic [3:0] cell_y;
      dir_type    direction;
      logic       finished;
   } carve_result_type;

   typedef struct packed {
      logic             restart;
      logic [1:0]       first;
      logic [1:0]       second;
      logic [1:0]       third;
      logic             typed;
      carve_result_type want;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_restart = 1'b0;
   logic [1:0] req_pick_first = 2'd0;
   logic [1:0] req_pick_second = 2'd0;
   logic [1:0] req_pick_third = 2'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_cell_x;
   logic [3:0] rsp_cell_y;
   dir_type    rsp_direction;
   logic       rsp_finished;

   // side-band that travels with each request: a hand-typed answer replaces the prediction
   logic             req_typed = 1'b0;
   carve_result_type req_want = '0;

   int               idle_pct = 0;
   int               stall_pct = 0;
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int               maze_len = 0;
   carve_result_type pending_carves[$];

   // carver state mirror
   bit [CELLS-1:0] seen_cells;
   logic [3:0]     frame_x[CELLS];
   logic [3:0]     frame_y[CELLS];
   dir_type        frame_order[CELLS][4];
   logic [2:0]     frame_next[CELLS];
   int             depth;
   logic [3:0]     next_x;
   logic [3:0]     next_y;
   bit             maze_done;

   random_dfs_maze_carver_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_restart     (req_restart),
      .req_pick_first  (req_pick_first),
      .req_pick_second (req_pick_second),
      .req_pick_third  (req_pick_third),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_x      (rsp_cell_x),
      .rsp_cell_y      (rsp_cell_y),
      .rsp_direction   (rsp_direction),
      .rsp_finished    (rsp_finished)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_maze();
      seen_cells = '0;
      depth      = 0;
      next_x     = 4'd0;
      next_y     = 4'd0;
      maze_done  = 1'b0;
   endfunction

   // enter the pending cell, then walk the stack to the next carve or to the end of the maze
   function automatic carve_result_type predict_carve(logic rst, logic [1:0] a,
                                                      logic [1:0] b, logic [1:0] c);
      carve_result_type res;
      dir_type          ord[4];
      logic [1:0]       picks[3];
      dir_type          t;
      dir_type          d;
      int               nx;
      int               ny;
      int               top;
      bit               found;
      res = '0;
      if (rst)
         clear_maze();
      if (maze_done) begin
         res.finished = 1'b1;
         return res;
      end
      seen_cells[{next_y, next_x}] = 1'b1;
      if (depth < CELLS) begin
         ord   = '{DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT};
         picks = '{a, b, c};
         for (int s = 0; s < 3; s++) begin
            t             = ord[s];
            ord[s]        = ord[picks[s]];
            ord[picks[s]] = t;
         end
         frame_x[depth]     = next_x;
         frame_y[depth]     = next_y;
         frame_order[depth] = ord;
         frame_next[depth]  = 3'd0;
         depth++;
      end
      found = 1'b0;
      while (depth > 0 && !found) begin
         top = depth - 1;
         while (frame_next[top] < 3'd4 && !found) begin
            d  = frame_order[top][frame_next[top][1:0]];
            frame_next[top]++;
            nx = frame_x[top];
            ny = frame_y[top];
            case (d)
               DIR_UP:    ny--;
               DIR_RIGHT: nx++;
               DIR_DOWN:  ny++;
               default:   nx--;
            endcase
            if (nx >= 0 && nx < COLS && ny >= 0 && ny < ROWS && !seen_cells[ny * COLS + nx]) begin
               found         = 1'b1;
               next_x        = nx[3:0];
               next_y        = ny[3:0];
               res.cell_x    = frame_x[top];
               res.cell_y    = frame_y[top];
               res.direction = d;
            end
         end
         if (!found)
            depth--;
      end
      if (!found) begin
         maze_done    = 1'b1;
         res.finished = 1'b1;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // scoreboard: retire the result transfer first, then queue the request just taken
   always @(posedge clock) begin
      carve_result_type got;
      carve_result_type want;
      if (reset) begin
         clear_maze();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_cell_x, rsp_cell_y, rsp_direction, rsp_finished};
            if (pending_carves.size() == 0) begin
               $error("result transfer with nothing outstanding: x %0d y %0d dir %0d fin %0d",
                      got.cell_x, got.cell_y, got.direction, got.finished);
               mismatch_count++;
            end else begin
               want = pending_carves.pop_front();
               if (got.cell_x !== want.cell_x) begin
                  $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
                  mismatch_count++;
               end
               if (got.cell_y !== want.cell_y) begin
                  $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
                  mismatch_count++;
               end
               if (got.direction !== want.direction) begin
                  $error("direction: expected %0d, got %0d", want.direction, got.direction);
                  mismatch_count++;
               end
               if (got.finished !== want.finished) begin
                  $error("finished: expected %0d, got %0d", want.finished, got.finished);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = predict_carve(req_restart, req_pick_first, req_pick_second, req_pick_third);
            pending_carves.push_back(req_typed ? req_want : want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_request(input logic rst, input logic [1:0] a, input logic [1:0] b,
                               input logic [1:0] c, input logic typed,
                               input carve_result_type want);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_restart     <= rst;
      req_pick_first  <= a;
      req_pick_second <= b;
      req_pick_third  <= c;
      req_typed       <= typed;
      req_want        <= want;
      do @(posedge clock); while (!req_ready);
      maze_len = rst ? 1 : maze_len + 1;
   endtask

   // hold the sender off until every outstanding result has been taken
   task automatic drain_carves();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_carves.size() != 0);
   endtask

   function automatic stim_row_type make_row(logic rst, logic [1:0] a, logic [1:0] b,
                                             logic [1:0] c, logic typed, dir_type dir);
      stim_row_type row;
      row         = '0;
      row.restart = rst;
      row.first   = a;
      row.second  = b;
      row.third   = c;
      row.typed   = typed;
      row.want.direction = dir;
      return row;
   endfunction

   initial begin
      stim_row_type directed_rows[$];
      stim_row_type row;
      logic         rst;
      int           idle_table[4];
      int           stall_table[4];
      // from (0,0) only right and down stay in the grid, so the first carve is easy to read
      directed_rows.push_back(make_row(1'b0, 2'd0, 2'd1, 2'd2, 1'b1, DIR_RIGHT));
      directed_rows.push_back(make_row(1'b0, 2'd3, 2'd3, 2'd3, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd2, 2'd1, 2'd2, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd1, 2'd2, 2'd3, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd0, 2'd0, 2'd0, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd3, 2'd2, 2'd1, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd1, 2'd1, 2'd1, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd2, 2'd3, 2'd0, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd0, 2'd3, 2'd3, 1'b0, DIR_UP));
      // restart mid-maze
      directed_rows.push_back(make_row(1'b1, 2'd2, 2'd1, 2'd2, 1'b1, DIR_DOWN));
      directed_rows.push_back(make_row(1'b0, 2'd3, 2'd1, 2'd3, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd2, 2'd2, 2'd2, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd1, 2'd3, 2'd2, 1'b0, DIR_UP));
      // picks below their nominal range still swap
      directed_rows.push_back(make_row(1'b1, 2'd0, 2'd0, 2'd0, 1'b1, DIR_DOWN));
      directed_rows.push_back(make_row(1'b0, 2'd3, 2'd0, 2'd1, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b0, 2'd0, 2'd2, 2'd3, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b1, 2'd3, 2'd3, 2'd3, 1'b1, DIR_RIGHT));
      directed_rows.push_back(make_row(1'b0, 2'd2, 2'd0, 2'd2, 1'b0, DIR_UP));
      directed_rows.push_back(make_row(1'b1, 2'd1, 2'd3, 2'd2, 1'b1, DIR_RIGHT));
      directed_rows.push_back(make_row(1'b0, 2'd1, 2'd0, 2'd3, 1'b0, DIR_UP));
      idle_table  = '{0, 53, 0, 34};
      stall_table = '{0, 0, 53, 34};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_request(row.restart, row.first, row.second, row.third, row.typed, row.want);
      end
      drain_carves();

      // whole mazes with random shuffles; a few finished answers, then a restart
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_table[p];
         stall_pct = stall_table[p];
         for (int n = 0; n < PHASE_LEN; n++) begin
            if (maze_len >= CELLS)
               rst = ($urandom_range(2) == 0);
            else
               rst = ($urandom_range(399) == 0);
            send_request(rst, 2'($urandom_range(3)), 2'($urandom_range(3)),
                         2'($urandom_range(3)), 1'b0, '0);
         end
         drain_carves();
      end

      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[random_dfs_maze_carver_core.f]
rtl/rdmc_pkg.sv
rtl/rdmc_ram.sv
rtl/rdmc_nbr_unit.sv
rtl/random_dfs_maze_carver_core.sv
tb/sv/random_dfs_maze_carver_core_tb.sv
